// File: hw/rtl/cbe_pkg.sv
// Package for the cubic Bezier easing block: widths, codes, controller states,
// command and status structs, and the sample-position table.
// No dependencies; used by every other RTL file.
`default_nettype none

package cbe_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int SAMPLE_COUNT = 11;
    localparam int NEWTON_STEPS = 4;
    localparam int BISECT_STEPS = 10;

    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = 1 << (FRAC_BITS - 1);
    localparam int MIN_SLOPE = ONE / 1000;
    localparam int OUT_LIM   = 4 * ONE;
    localparam int SAMP_DEN  = 2 * (SAMPLE_COUNT - 1);

    localparam int X_W     = 17;
    localparam int Y_W     = 19;
    localparam int OUT_W   = 20;
    localparam int T_W     = X_W;
    localparam int ACC_W   = 26;
    localparam int DVD_W   = ACC_W + FRAC_BITS + 1;
    localparam int DVS_W   = ACC_W;
    localparam int Q_W     = DVD_W + 1;
    localparam int IDX_W   = $clog2(SAMPLE_COUNT + 1);
    localparam int CNT_W   = $clog2(BISECT_STEPS + NEWTON_STEPS + 1);
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W   = Y_W;

    localparam logic [CFG_IDX_W-1:0] REG_X1 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_X2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_Y2 = CFG_IDX_W'(3);

    typedef enum logic [5:0] {
        ST_TB_START, ST_TB_L, ST_TB_M1, ST_TB_M2, ST_TB_M3, ST_TB_WR,
        ST_IDLE, ST_CHECK, ST_SCAN, ST_LOADK, ST_IP, ST_IP_DIV, ST_IP_FIN,
        ST_S0_L, ST_S0_M1, ST_S0_M2, ST_S0_CHK,
        ST_NW_L, ST_NW_M1, ST_NW_M2, ST_NW_CHK,
        ST_NWC_L, ST_NWC_M1, ST_NWC_M2, ST_NWC_M3,
        ST_NW_DIVLD, ST_NW_DIV, ST_NW_FIN,
        ST_BI_MID, ST_BIC_L, ST_BIC_M1, ST_BIC_M2, ST_BIC_M3, ST_BI_UPD,
        ST_Y_L, ST_Y_M1, ST_Y_M2, ST_Y_M3, ST_Y_FIN, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_CFG_WR, DP_IN_LOAD, DP_IDX_CLR, DP_P_LOAD, DP_P_STEP,
        DP_TAB_WR, DP_SCAN_INIT, DP_SCAN, DP_LOADK, DP_T_T0, DP_IP_DIVLD,
        DP_T_INTERP, DP_CNT_CLR, DP_SL_SAVE, DP_NW_DIVLD, DP_T_NEWTON,
        DP_BI_INIT, DP_BI_MID, DP_BI_UPD, DP_Y_BYPASS, DP_Y_OUT
    } t_dp_op;

    typedef enum logic [1:0] {TS_SAMPLE, TS_CUR, TS_MID} t_tsel;
    typedef enum logic [1:0] {AD_B, AD_C, AD_ZERO} t_add;

    typedef struct packed {
        t_dp_op op;
        logic   coef_y;
        logic   slope;
        t_tsel  tsel;
        t_add   addsel;
    } t_dp_cmd;

    typedef struct packed {
        logic bypass;
        logic scan_go;
        logic den_zero;
        logic idx_last;
        logic div_done;
        logic acc_zero;
        logic slope_ok;
        logic cx_zero;
        logic nw_last;
        logic bi_last;
    } t_dp_stat;

    // Curve parameter of sample i, rounded to nearest.
    function automatic logic [T_W-1:0] f_samp_t(input logic [IDX_W-1:0] i);
        logic [T_W-1:0] r;
        r = '0;
        for (int j = 0; j < SAMPLE_COUNT; j++) begin
            if (i == IDX_W'(j)) begin
                r = T_W'((2 * j * ONE + SAMPLE_COUNT - 1) / SAMP_DEN);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cbe_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on cbe_pkg for widths.
`default_nettype none

module cbe_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [cbe_pkg::DVD_W-1:0] i_dividend,
    input  wire logic signed [cbe_pkg::DVS_W-1:0] i_divisor,
    output logic                                 o_done,
    output logic signed [cbe_pkg::Q_W-1:0]       o_quotient
);

    localparam int DW = cbe_pkg::DVD_W;
    localparam int SW = cbe_pkg::DVS_W;
    localparam int CW = $clog2(DW);

    logic [SW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [SW-1:0] r_dvs;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW-1:0] dvd_mag;
    logic [SW-1:0] dvs_mag;
    logic [SW:0]   sh;
    logic          ge;

    assign dvd_mag = i_dividend[DW-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign dvs_mag = i_divisor[SW-1] ? (~i_divisor + 1'b1) : i_divisor;
    assign sh      = {r_rem, r_quo[DW-1]};
    assign ge      = sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= dvd_mag;
            r_dvs <= dvs_mag;
            r_neg <= i_dividend[DW-1] ^ i_divisor[SW-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? SW'(sh - {1'b0, r_dvs}) : sh[SW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

`default_nettype wire

// File: hw/rtl/cbe_dp.sv
// Datapath: control point registers, sample table, shared Horner multiplier,
// root-finding registers and the divider. Depends on cbe_pkg and cbe_div.
`default_nettype none

module cbe_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cbe_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [cbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cbe_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic [cbe_pkg::X_W-1:0]           i_progress,
    output cbe_pkg::t_dp_stat                      o_stat,
    output logic signed [cbe_pkg::OUT_W-1:0]       o_eased
);

    localparam int X_W   = cbe_pkg::X_W;
    localparam int Y_W   = cbe_pkg::Y_W;
    localparam int T_W   = cbe_pkg::T_W;
    localparam int A_W   = cbe_pkg::ACC_W;
    localparam int IDX_W = cbe_pkg::IDX_W;
    localparam int Q_W   = cbe_pkg::Q_W;
    localparam int DW    = cbe_pkg::DVD_W;
    localparam int SW    = cbe_pkg::DVS_W;
    localparam int PW    = A_W + T_W + 1;
    localparam int TSW   = Q_W + 1;
    localparam int D_W   = X_W + 1;

    localparam logic [X_W-1:0]        X_ONE  = X_W'(cbe_pkg::ONE);
    localparam logic signed [Y_W-1:0] Y_ONE  = Y_W'(cbe_pkg::ONE);
    localparam logic signed [A_W-1:0] A_ONE  = A_W'(cbe_pkg::ONE);
    localparam logic signed [A_W-1:0] A_MIN  = A_W'(cbe_pkg::MIN_SLOPE);
    localparam logic signed [A_W-1:0] A_LIM  = A_W'(cbe_pkg::OUT_LIM);
    localparam logic signed [PW-1:0]  P_HALF = PW'(cbe_pkg::HALF);
    localparam logic signed [TSW-1:0] S_ONE  = TSW'(cbe_pkg::ONE);

    logic [X_W-1:0]        r_x1, r_x2, r_x;
    logic signed [Y_W-1:0] r_y1, r_y2;
    logic [X_W-1:0]        r_tab [cbe_pkg::SAMPLE_COUNT];
    logic [IDX_W-1:0]      r_idx, r_k;
    logic [X_W-1:0]        r_sk, r_sk1;
    logic [T_W-1:0]        r_t, r_lo, r_hi, r_mid;
    logic signed [A_W-1:0] r_acc, r_sl;
    logic [cbe_pkg::CNT_W-1:0] r_cnt;
    logic signed [cbe_pkg::OUT_W-1:0] r_eased;

    logic [X_W-1:0]        ex1, ex2, x_in, tab_k, tab_val;
    logic signed [A_W-1:0] a1, a2, a1x3, a2x3, ca, cb, cc, load_val, addend, step_val, x_a;
    logic [T_W-1:0]        t_op, t0, t1, dt;
    logic signed [PW-1:0]  prod, rsum, rshift;
    logic signed [D_W-1:0] dx, den;
    logic signed [DW-1:0]  ip_num, nw_num, dvd;
    logic signed [SW-1:0]  dvs;
    logic                  div_start, div_done;
    logic signed [Q_W-1:0] q;
    logic signed [TSW-1:0] q_x, t0_x, t_x, t_ip, t_nw;
    logic [T_W-1:0]        t_ip_c, t_nw_c;
    logic signed [A_W-1:0] y_c;

    // Effective control points and Horner coefficients of the selected axis.
    assign ex1  = (r_x1 > X_ONE) ? X_ONE : r_x1;
    assign ex2  = (r_x2 > X_ONE) ? X_ONE : r_x2;
    assign x_in = (i_progress > X_ONE) ? X_ONE : i_progress;

    assign a1 = i_cmd.coef_y ? A_W'(r_y1) : $signed({{(A_W - X_W){1'b0}}, ex1});
    assign a2 = i_cmd.coef_y ? A_W'(r_y2) : $signed({{(A_W - X_W){1'b0}}, ex2});
    assign a1x3 = (a1 <<< 1) + a1;
    assign a2x3 = (a2 <<< 1) + a2;
    assign ca   = A_ONE - a2x3 + a1x3;
    assign cb   = a2x3 - (a1x3 <<< 1);
    assign cc   = a1x3;

    assign load_val = i_cmd.slope ? ((ca <<< 1) + ca) : ca;

    always_comb begin
        case (i_cmd.addsel)
            cbe_pkg::AD_B:    addend = i_cmd.slope ? (cb <<< 1) : cb;
            cbe_pkg::AD_C:    addend = cc;
            default:          addend = '0;
        endcase
        case (i_cmd.tsel)
            cbe_pkg::TS_SAMPLE: t_op = cbe_pkg::f_samp_t(r_idx);
            cbe_pkg::TS_MID:    t_op = r_mid;
            default:            t_op = r_t;
        endcase
    end

    // Rounded fixed-point product, floor((a*t + half) / one).
    assign prod     = r_acc * $signed({1'b0, t_op});
    assign rsum     = prod + P_HALF;
    assign rshift   = rsum >>> cbe_pkg::FRAC_BITS;
    assign step_val = rshift[A_W-1:0] + addend;

    assign tab_val = r_acc[A_W-1] ? '0 : ((r_acc > A_ONE) ? X_ONE : r_acc[X_W-1:0]);
    assign tab_k   = r_tab[r_k];
    assign t0      = cbe_pkg::f_samp_t(r_k);
    assign t1      = cbe_pkg::f_samp_t(r_k + 1'b1);
    assign dt      = t1 - t0;

    assign dx     = $signed({1'b0, r_x}) - $signed({1'b0, r_sk});
    assign den    = $signed({1'b0, r_sk1}) - $signed({1'b0, r_sk});
    assign ip_num = DW'(dx * $signed({1'b0, dt}));
    assign x_a    = $signed({{(A_W - X_W){1'b0}}, r_x});
    assign nw_num = DW'(r_acc - x_a) <<< cbe_pkg::FRAC_BITS;

    assign div_start = (i_cmd.op == cbe_pkg::DP_IP_DIVLD) || (i_cmd.op == cbe_pkg::DP_NW_DIVLD);
    assign dvd = (i_cmd.op == cbe_pkg::DP_IP_DIVLD) ? ip_num : nw_num;
    assign dvs = (i_cmd.op == cbe_pkg::DP_IP_DIVLD) ? SW'(den) : r_sl;

    cbe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (q)
    );

    // Parameter updates, clamped to 0..one.
    assign q_x    = TSW'(q);
    assign t0_x   = $signed({{(TSW - T_W){1'b0}}, t0});
    assign t_x    = $signed({{(TSW - T_W){1'b0}}, r_t});
    assign t_ip   = t0_x + q_x;
    assign t_nw   = t_x - q_x;
    assign t_ip_c = t_ip[TSW-1] ? '0 : ((t_ip > S_ONE) ? X_ONE : t_ip[T_W-1:0]);
    assign t_nw_c = t_nw[TSW-1] ? '0 : ((t_nw > S_ONE) ? X_ONE : t_nw[T_W-1:0]);

    assign y_c = (r_acc > A_LIM) ? A_LIM : ((r_acc < -A_LIM) ? -A_LIM : r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_y1 <= '0;
            r_x2 <= X_ONE;
            r_y2 <= Y_ONE;
        end else if (i_cmd.op == cbe_pkg::DP_CFG_WR) begin
            case (i_cfg_index)
                cbe_pkg::REG_X1: r_x1 <= i_cfg_data[X_W-1:0];
                cbe_pkg::REG_Y1: r_y1 <= $signed(i_cfg_data[Y_W-1:0]);
                cbe_pkg::REG_X2: r_x2 <= i_cfg_data[X_W-1:0];
                cbe_pkg::REG_Y2: r_y2 <= $signed(i_cfg_data[Y_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cbe_pkg::DP_IN_LOAD:   r_x <= x_in;
            cbe_pkg::DP_IDX_CLR:   r_idx <= '0;
            cbe_pkg::DP_P_LOAD:    r_acc <= load_val;
            cbe_pkg::DP_P_STEP:    r_acc <= step_val;
            cbe_pkg::DP_TAB_WR: begin
                r_tab[r_idx] <= tab_val;
                r_idx        <= r_idx + 1'b1;
            end
            cbe_pkg::DP_SCAN_INIT: r_k <= IDX_W'(1);
            cbe_pkg::DP_SCAN: begin
                if (o_stat.scan_go) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    r_sk1 <= tab_k;
                    r_k   <= r_k - 1'b1;
                end
            end
            cbe_pkg::DP_LOADK:     r_sk <= tab_k;
            cbe_pkg::DP_T_T0:      r_t <= t0;
            cbe_pkg::DP_T_INTERP:  r_t <= t_ip_c;
            cbe_pkg::DP_CNT_CLR:   r_cnt <= '0;
            cbe_pkg::DP_SL_SAVE:   r_sl <= r_acc;
            cbe_pkg::DP_T_NEWTON: begin
                r_t   <= t_nw_c;
                r_cnt <= r_cnt + 1'b1;
            end
            cbe_pkg::DP_BI_INIT: begin
                r_lo  <= t0;
                r_hi  <= t1;
                r_cnt <= '0;
            end
            cbe_pkg::DP_BI_MID:    r_mid <= r_lo + ((r_hi - r_lo) >> 1);
            cbe_pkg::DP_BI_UPD: begin
                if (r_acc > x_a) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid;
                end
                r_t   <= r_mid;
                r_cnt <= r_cnt + 1'b1;
            end
            cbe_pkg::DP_Y_BYPASS:  r_eased <= $signed({{(cbe_pkg::OUT_W - X_W){1'b0}}, r_x});
            cbe_pkg::DP_Y_OUT:     r_eased <= y_c[cbe_pkg::OUT_W-1:0];
            default: ;
        endcase
    end

    assign o_stat.bypass   = (r_x == '0) || (r_x == X_ONE) ||
                             (($signed({2'b0, ex1}) == r_y1) && ($signed({2'b0, ex2}) == r_y2));
    assign o_stat.scan_go  = (r_k != IDX_W'(cbe_pkg::SAMPLE_COUNT - 1)) && (tab_k <= r_x);
    assign o_stat.den_zero = (r_sk1 == r_sk);
    assign o_stat.idx_last = (r_idx == IDX_W'(cbe_pkg::SAMPLE_COUNT - 1));
    assign o_stat.div_done = div_done;
    assign o_stat.acc_zero = (r_acc == '0);
    assign o_stat.slope_ok = (r_acc >= A_MIN);
    assign o_stat.cx_zero  = (r_acc == x_a);
    assign o_stat.nw_last  = (r_cnt == cbe_pkg::CNT_W'(cbe_pkg::NEWTON_STEPS - 1));
    assign o_stat.bi_last  = (r_cnt == cbe_pkg::CNT_W'(cbe_pkg::BISECT_STEPS - 1));

    assign o_eased = r_eased;

endmodule

`default_nettype wire

// File: hw/rtl/cbe_ctrl.sv
// Sequencer: table rebuild, sample scan, interpolation, Newton or bisection,
// final y evaluation and the handshakes. Depends on cbe_pkg.
`default_nettype none

module cbe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire logic              i_cfg_valid,
    input  wire cbe_pkg::t_dp_stat i_stat,
    output cbe_pkg::t_dp_cmd       o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output logic                   o_cfg_ready
);

    cbe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbe_pkg::ST_TB_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = cbe_pkg::DP_NOP;
        o_cmd.coef_y  = 1'b0;
        o_cmd.slope   = 1'b0;
        o_cmd.tsel    = cbe_pkg::TS_CUR;
        o_cmd.addsel  = cbe_pkg::AD_ZERO;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cfg_ready   = 1'b0;
        case (r_state)
            cbe_pkg::ST_TB_START: begin
                o_cmd.op = cbe_pkg::DP_IDX_CLR;
                n_state  = cbe_pkg::ST_TB_L;
            end
            cbe_pkg::ST_TB_L: begin
                o_cmd.op = cbe_pkg::DP_P_LOAD;
                n_state  = cbe_pkg::ST_TB_M1;
            end
            cbe_pkg::ST_TB_M1: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.tsel = cbe_pkg::TS_SAMPLE;
                o_cmd.addsel = cbe_pkg::AD_B;
                n_state  = cbe_pkg::ST_TB_M2;
            end
            cbe_pkg::ST_TB_M2: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.tsel = cbe_pkg::TS_SAMPLE;
                o_cmd.addsel = cbe_pkg::AD_C;
                n_state  = cbe_pkg::ST_TB_M3;
            end
            cbe_pkg::ST_TB_M3: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.tsel = cbe_pkg::TS_SAMPLE;
                n_state  = cbe_pkg::ST_TB_WR;
            end
            cbe_pkg::ST_TB_WR: begin
                o_cmd.op = cbe_pkg::DP_TAB_WR;
                n_state  = i_stat.idx_last ? cbe_pkg::ST_IDLE : cbe_pkg::ST_TB_L;
            end
            cbe_pkg::ST_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.op = cbe_pkg::DP_CFG_WR;
                    n_state  = cbe_pkg::ST_TB_START;
                end else if (i_in_valid) begin
                    o_cmd.op = cbe_pkg::DP_IN_LOAD;
                    n_state  = cbe_pkg::ST_CHECK;
                end
            end
            cbe_pkg::ST_CHECK: begin
                if (i_stat.bypass) begin
                    o_cmd.op = cbe_pkg::DP_Y_BYPASS;
                    n_state  = cbe_pkg::ST_OUT;
                end else begin
                    o_cmd.op = cbe_pkg::DP_SCAN_INIT;
                    n_state  = cbe_pkg::ST_SCAN;
                end
            end
            cbe_pkg::ST_SCAN: begin
                o_cmd.op = cbe_pkg::DP_SCAN;
                if (!i_stat.scan_go) n_state = cbe_pkg::ST_LOADK;
            end
            cbe_pkg::ST_LOADK: begin
                o_cmd.op = cbe_pkg::DP_LOADK;
                n_state  = cbe_pkg::ST_IP;
            end
            cbe_pkg::ST_IP: begin
                if (i_stat.den_zero) begin
                    o_cmd.op = cbe_pkg::DP_T_T0;
                    n_state  = cbe_pkg::ST_S0_L;
                end else begin
                    o_cmd.op = cbe_pkg::DP_IP_DIVLD;
                    n_state  = cbe_pkg::ST_IP_DIV;
                end
            end
            cbe_pkg::ST_IP_DIV: begin
                if (i_stat.div_done) n_state = cbe_pkg::ST_IP_FIN;
            end
            cbe_pkg::ST_IP_FIN: begin
                o_cmd.op = cbe_pkg::DP_T_INTERP;
                n_state  = cbe_pkg::ST_S0_L;
            end
            cbe_pkg::ST_S0_L: begin
                o_cmd.op = cbe_pkg::DP_P_LOAD; o_cmd.slope = 1'b1;
                n_state  = cbe_pkg::ST_S0_M1;
            end
            cbe_pkg::ST_S0_M1: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.slope = 1'b1;
                o_cmd.addsel = cbe_pkg::AD_B;
                n_state  = cbe_pkg::ST_S0_M2;
            end
            cbe_pkg::ST_S0_M2: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.slope = 1'b1;
                o_cmd.addsel = cbe_pkg::AD_C;
                n_state  = cbe_pkg::ST_S0_CHK;
            end
            cbe_pkg::ST_S0_CHK: begin
                if (i_stat.slope_ok) begin
                    o_cmd.op = cbe_pkg::DP_CNT_CLR;
                    n_state  = cbe_pkg::ST_NW_L;
                end else if (i_stat.acc_zero) begin
                    n_state  = cbe_pkg::ST_Y_L;
                end else begin
                    o_cmd.op = cbe_pkg::DP_BI_INIT;
                    n_state  = cbe_pkg::ST_BI_MID;
                end
            end
            cbe_pkg::ST_NW_L: begin
                o_cmd.op = cbe_pkg::DP_P_LOAD; o_cmd.slope = 1'b1;
                n_state  = cbe_pkg::ST_NW_M1;
            end
            cbe_pkg::ST_NW_M1: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.slope = 1'b1;
                o_cmd.addsel = cbe_pkg::AD_B;
                n_state  = cbe_pkg::ST_NW_M2;
            end
            cbe_pkg::ST_NW_M2: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.slope = 1'b1;
                o_cmd.addsel = cbe_pkg::AD_C;
                n_state  = cbe_pkg::ST_NW_CHK;
            end
            cbe_pkg::ST_NW_CHK: begin
                o_cmd.op = cbe_pkg::DP_SL_SAVE;
                n_state  = i_stat.acc_zero ? cbe_pkg::ST_Y_L : cbe_pkg::ST_NWC_L;
            end
            cbe_pkg::ST_NWC_L: begin
                o_cmd.op = cbe_pkg::DP_P_LOAD;
                n_state  = cbe_pkg::ST_NWC_M1;
            end
            cbe_pkg::ST_NWC_M1: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.addsel = cbe_pkg::AD_B;
                n_state  = cbe_pkg::ST_NWC_M2;
            end
            cbe_pkg::ST_NWC_M2: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.addsel = cbe_pkg::AD_C;
                n_state  = cbe_pkg::ST_NWC_M3;
            end
            cbe_pkg::ST_NWC_M3: begin
                o_cmd.op = cbe_pkg::DP_P_STEP;
                n_state  = cbe_pkg::ST_NW_DIVLD;
            end
            cbe_pkg::ST_NW_DIVLD: begin
                o_cmd.op = cbe_pkg::DP_NW_DIVLD;
                n_state  = cbe_pkg::ST_NW_DIV;
            end
            cbe_pkg::ST_NW_DIV: begin
                if (i_stat.div_done) n_state = cbe_pkg::ST_NW_FIN;
            end
            cbe_pkg::ST_NW_FIN: begin
                o_cmd.op = cbe_pkg::DP_T_NEWTON;
                n_state  = i_stat.nw_last ? cbe_pkg::ST_Y_L : cbe_pkg::ST_NW_L;
            end
            cbe_pkg::ST_BI_MID: begin
                o_cmd.op = cbe_pkg::DP_BI_MID;
                n_state  = cbe_pkg::ST_BIC_L;
            end
            cbe_pkg::ST_BIC_L: begin
                o_cmd.op = cbe_pkg::DP_P_LOAD;
                n_state  = cbe_pkg::ST_BIC_M1;
            end
            cbe_pkg::ST_BIC_M1: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.tsel = cbe_pkg::TS_MID;
                o_cmd.addsel = cbe_pkg::AD_B;
                n_state  = cbe_pkg::ST_BIC_M2;
            end
            cbe_pkg::ST_BIC_M2: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.tsel = cbe_pkg::TS_MID;
                o_cmd.addsel = cbe_pkg::AD_C;
                n_state  = cbe_pkg::ST_BIC_M3;
            end
            cbe_pkg::ST_BIC_M3: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.tsel = cbe_pkg::TS_MID;
                n_state  = cbe_pkg::ST_BI_UPD;
            end
            cbe_pkg::ST_BI_UPD: begin
                o_cmd.op = cbe_pkg::DP_BI_UPD;
                n_state  = (i_stat.cx_zero || i_stat.bi_last) ? cbe_pkg::ST_Y_L
                                                              : cbe_pkg::ST_BI_MID;
            end
            cbe_pkg::ST_Y_L: begin
                o_cmd.op = cbe_pkg::DP_P_LOAD; o_cmd.coef_y = 1'b1;
                n_state  = cbe_pkg::ST_Y_M1;
            end
            cbe_pkg::ST_Y_M1: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.coef_y = 1'b1;
                o_cmd.addsel = cbe_pkg::AD_B;
                n_state  = cbe_pkg::ST_Y_M2;
            end
            cbe_pkg::ST_Y_M2: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.coef_y = 1'b1;
                o_cmd.addsel = cbe_pkg::AD_C;
                n_state  = cbe_pkg::ST_Y_M3;
            end
            cbe_pkg::ST_Y_M3: begin
                o_cmd.op = cbe_pkg::DP_P_STEP; o_cmd.coef_y = 1'b1;
                n_state  = cbe_pkg::ST_Y_FIN;
            end
            cbe_pkg::ST_Y_FIN: begin
                o_cmd.op = cbe_pkg::DP_Y_OUT;
                n_state  = cbe_pkg::ST_OUT;
            end
            cbe_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = cbe_pkg::ST_IDLE;
            end
            default: n_state = cbe_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/cubic_bezier_easing_top.sv
// Top level of the cubic Bezier easing evaluator: sequencer plus datapath.
// Depends on cbe_pkg, cbe_ctrl, cbe_dp (which holds cbe_div).
//
//   Channel  Direction  Handshake                    Payload
//   in       sink       i_in_valid / o_in_ready      i_progress  (17b, unsigned)
//   out      source     o_out_valid / i_out_ready    o_eased     (20b, signed)
//   cfg      sink       i_cfg_valid / o_cfg_ready    i_cfg_index (8b), i_cfg_data (19b)
//
// One item at a time. Endpoints and the identity curve skip the solver;
// otherwise an item's time is set by the bit-serial divider (one division
// for interpolation and one per Newton step) and the shared Horner
// multiplier (one product per cycle).
// After reset and after every config write the 11-entry sample table is
// rebuilt; no item is taken meanwhile.
// A stalled result holds in the output register until the item is taken.
`default_nettype none

module cubic_bezier_easing_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [cbe_pkg::X_W-1:0]           i_progress,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [cbe_pkg::OUT_W-1:0]       o_eased,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [cbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cbe_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam logic signed [cbe_pkg::OUT_W-1:0] LIM = cbe_pkg::OUT_W'(cbe_pkg::OUT_LIM);

    cbe_pkg::t_dp_cmd  cmd;
    cbe_pkg::t_dp_stat stat;

    // Sequencer: owns all handshakes and walks the root-finding steps.
    cbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cfg_ready (o_cfg_ready)
    );

    // Datapath: registers, table, multiplier and divider.
    cbe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_progress  (i_progress),
        .o_stat      (stat),
        .o_eased     (o_eased)
    );

    // A result waiting at the output blocks new input.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result waits");

    // An accepted item makes the block busy on the next cycle.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && !o_cfg_ready))
        else $error("ready right after accepting an item");

    // A config write starts a table rebuild.
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (!o_in_ready && !o_out_valid))
        else $error("no rebuild after config write");

    // Results stay inside the saturation range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_eased <= LIM) && (o_eased >= -LIM)))
        else $error("eased value out of range");

endmodule

`default_nettype wire

// File: tb/cubic_bezier_easing_checker.sv
// Checker for the cubic Bezier easing block: mirrors the register file and
// sample table, predicts each eased value and compares it with the output item.
// Depends on cbe_pkg for widths and register indexes.
`timescale 1ns / 1ps

module cubic_bezier_easing_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [cbe_pkg::X_W-1:0]           i_progress,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [cbe_pkg::OUT_W-1:0]  i_eased,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [cbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbe_pkg::CFG_W-1:0]         i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam longint UNIT = longint'(cbe_pkg::ONE);

    logic [cbe_pkg::X_W-1:0]   reg_x1, reg_x2;
    logic [cbe_pkg::Y_W-1:0]   reg_y1, reg_y2;
    longint                    samples [cbe_pkg::SAMPLE_COUNT];
    logic [cbe_pkg::OUT_W-1:0] eased_q [$];
    int                        out_seen;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Rounded product; arithmetic shift gives floor for negative sums too.
    function automatic longint fmul(longint a, longint b);
        return (a * b + longint'(cbe_pkg::HALF)) >>> cbe_pkg::FRAC_BITS;
    endfunction

    function automatic longint bez(longint t, longint a1, longint a2);
        longint ca, cb, cc;
        ca = UNIT - 3 * a2 + 3 * a1;
        cb = 3 * a2 - 6 * a1;
        cc = 3 * a1;
        return fmul(fmul(fmul(ca, t) + cb, t) + cc, t);
    endfunction

    function automatic longint bez_slope(longint t, longint a1, longint a2);
        longint ca, cb, cc;
        ca = UNIT - 3 * a2 + 3 * a1;
        cb = 3 * a2 - 6 * a1;
        cc = 3 * a1;
        return fmul(fmul(3 * ca, t) + 2 * cb, t) + cc;
    endfunction

    function automatic longint knot_t(longint i);
        return (2 * i * UNIT + (cbe_pkg::SAMPLE_COUNT - 1)) /
               (2 * (cbe_pkg::SAMPLE_COUNT - 1));
    endfunction

    function automatic longint sext_y(logic [cbe_pkg::Y_W-1:0] r);
        return longint'(signed'(r));
    endfunction

    task automatic rebuild_samples();
        longint x1, x2;
        x1 = clip(longint'(reg_x1), 0, UNIT);
        x2 = clip(longint'(reg_x2), 0, UNIT);
        for (int i = 0; i < cbe_pkg::SAMPLE_COUNT; i++)
            samples[i] = clip(bez(knot_t(i), x1, x2), 0, UNIT);
    endtask

    function automatic longint solve_t(longint x, longint x1, longint x2);
        int k;
        longint t0, t1, den, t, s, sl, lo, hi, mid, cx;
        int n;
        k = 1;
        while (k != cbe_pkg::SAMPLE_COUNT - 1 && samples[k] <= x) k++;
        k--;
        t0 = knot_t(k);
        t1 = knot_t(k + 1);
        den = samples[k + 1] - samples[k];
        t = t0;
        if (den != 0) t = t0 + (x - samples[k]) * (t1 - t0) / den;
        t = clip(t, 0, UNIT);
        s = bez_slope(t, x1, x2);
        if (s >= longint'(cbe_pkg::MIN_SLOPE)) begin
            for (int i = 0; i < cbe_pkg::NEWTON_STEPS; i++) begin
                sl = bez_slope(t, x1, x2);
                if (sl == 0) return t;
                t = clip(t - (bez(t, x1, x2) - x) * UNIT / sl, 0, UNIT);
            end
            return t;
        end
        if (s == 0) return t;
        lo = t0;
        hi = t1;
        n = 0;
        do begin
            mid = lo + ((hi - lo) >>> 1);
            cx = bez(mid, x1, x2) - x;
            if (cx > 0) hi = mid;
            else lo = mid;
            n++;
        end while (cx != 0 && n < cbe_pkg::BISECT_STEPS);
        return mid;
    endfunction

    function automatic logic [cbe_pkg::OUT_W-1:0] ease_value(logic [cbe_pkg::X_W-1:0] p);
        longint x, x1, x2, y1, y2, y;
        x  = clip(longint'(p), 0, UNIT);
        x1 = clip(longint'(reg_x1), 0, UNIT);
        x2 = clip(longint'(reg_x2), 0, UNIT);
        y1 = sext_y(reg_y1);
        y2 = sext_y(reg_y2);
        if (x == 0 || x == UNIT || (x1 == y1 && x2 == y2)) begin
            y = x;
        end else begin
            y = bez(solve_t(x, x1, x2), y1, y2);
            y = clip(y, -longint'(cbe_pkg::OUT_LIM), longint'(cbe_pkg::OUT_LIM));
        end
        return cbe_pkg::OUT_W'(y);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch @%0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        out_seen     = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_x1 = '0;
            reg_y1 = '0;
            reg_x2 = cbe_pkg::X_W'(cbe_pkg::ONE);
            reg_y2 = cbe_pkg::Y_W'(cbe_pkg::ONE);
            rebuild_samples();
            eased_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cbe_pkg::REG_X1: reg_x1 = i_cfg_data[cbe_pkg::X_W-1:0];
                    cbe_pkg::REG_Y1: reg_y1 = i_cfg_data;
                    cbe_pkg::REG_X2: reg_x2 = i_cfg_data[cbe_pkg::X_W-1:0];
                    cbe_pkg::REG_Y2: reg_y2 = i_cfg_data;
                    default: ;
                endcase
                rebuild_samples();
            end
            if (i_in_valid && i_in_ready)
                eased_q.push_back(ease_value(i_progress));
            if (i_out_valid && i_out_ready) begin
                out_seen++;
                if (eased_q.size() == 0)
                    report_mismatch($sformatf("unexpected item eased=%0d", i_eased));
                else if (eased_q[0] !== i_eased)
                    report_mismatch($sformatf("item %0d eased got %0d want %0d",
                        out_seen, i_eased, signed'(eased_q[0])));
                if (eased_q.size() != 0) void'(eased_q.pop_front());
            end
        end
        o_pending = eased_q.size();
    end

endmodule

// File: tb/cubic_bezier_easing_top_tb.sv
// Testbench top for the cubic Bezier easing block: clock, reset, stimulus,
// idling, watchdog and verdict. Depends on cbe_pkg, the block and the checker.
`timescale 1ns / 1ps

module cubic_bezier_easing_top_tb;

    localparam int RAND_PER_SET = 75;
    localparam int DRAIN_WAIT   = 400;     // longer than the slowest item
    localparam int HOLD_CYCLES  = 3000;    // long receiver stall
    localparam int WATCH_LIMIT  = 40000;   // cycles with no accepted item

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [cbe_pkg::X_W-1:0]        i_progress = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic signed [cbe_pkg::OUT_W-1:0] o_eased;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [cbe_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [cbe_pkg::CFG_W-1:0]      i_cfg_data = '0;

    int fail_count, pending;
    int snd_idle = 30;     // percent of offers preceded by an idle cycle
    int rcv_idle = 60;     // percent of cycles with ready low
    bit hold_req = 0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    cubic_bezier_easing_top u_dut (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_progress,
        .o_out_valid, .i_out_ready, .o_eased,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    cubic_bezier_easing_checker u_check (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_progress,
        .i_out_valid(o_out_valid), .i_out_ready, .i_eased(o_eased),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Watchdog: count cycles in which no channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one item; hold valid and payload until accepted.
    task automatic offer_progress(input logic [cbe_pkg::X_W-1:0] p);
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_progress <= p;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Lower valid, then wait until every expected item is back and the block is idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [cbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbe_pkg::CFG_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly interior progress values; some endpoints and values above one.
    function automatic logic [cbe_pkg::X_W-1:0] pick_progress();
        int r;
        r = $urandom_range(99);
        if (r < 3) return '0;
        if (r < 6) return cbe_pkg::X_W'(cbe_pkg::ONE);
        if (r < 11) return cbe_pkg::X_W'($urandom_range(131071, cbe_pkg::ONE + 1));
        return cbe_pkg::X_W'($urandom_range(cbe_pkg::ONE - 1, 1));
    endfunction

    logic [cbe_pkg::CFG_W-1:0] cfg_set [9][4];
    logic [cbe_pkg::X_W-1:0]   edge_pts [8];
    int                        total;

    initial begin
        // ease, extremes both ways, zero slope mid-curve, x above range, randoms
        cfg_set[0] = '{19'd16384, 19'd6554, 19'd16384, 19'd65536};
        cfg_set[1] = '{19'd0, 19'h60000, 19'd65536, 19'd196608};
        cfg_set[2] = '{19'd65536, 19'd196608, 19'd0, 19'h60000};
        cfg_set[3] = '{19'd65536, 19'd0, 19'd0, 19'd65536};
        cfg_set[4] = '{19'h7FFFF, 19'd30000, 19'h1FFFF, 19'd70000};
        for (int s = 5; s < 9; s++)
            for (int r = 0; r < 4; r++)
                cfg_set[s][r] = cbe_pkg::CFG_W'($urandom);
        edge_pts = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'd65537,
                     17'h1FFFF, 17'd6554};
        total = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset curve is the identity: a few directed items through it.
        for (int i = 0; i < 4; i++) offer_progress(edge_pts[i + 2]);
        drain_results();

        for (int s = 0; s < 9; s++) begin
            write_reg(cbe_pkg::REG_X1, cfg_set[s][0]);
            write_reg(cbe_pkg::REG_Y1, cfg_set[s][1]);
            write_reg(cbe_pkg::REG_X2, cfg_set[s][2]);
            write_reg(cbe_pkg::REG_Y2, cfg_set[s][3]);
            // A write to an unused index must leave the curve alone.
            write_reg(cbe_pkg::CFG_IDX_W'($urandom_range(255, 4)),
                      cbe_pkg::CFG_W'($urandom));
            if (s < 3)
                foreach (edge_pts[i]) offer_progress(edge_pts[i]);
            if (s == 3) hold_req = 1;   // fill the block while the receiver stalls
            for (int n = 0; n < RAND_PER_SET; n++) begin
                // Swap the idling pattern at one third, drop it at two thirds.
                if (total == 9 * RAND_PER_SET / 3) begin
                    snd_idle = 60;
                    rcv_idle = 30;
                end else if (total == 2 * 9 * RAND_PER_SET / 3) begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
                offer_progress(pick_progress());
                total++;
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
